// ===== hw/rtl/animation_frame_sequencer_defines.svh =====
// Assertion macros used by the sequencer checker.
// Expects signals named clk and rst in the scope of use.
`ifndef ANIMATION_FRAME_SEQUENCER_DEFINES_SVH
`define ANIMATION_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/afs_pkg.sv =====
// Shared constants, field widths and codes for the animation frame sequencer.
// No dependencies; used by the top level and its checker.
package afs_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = FRAME_W + 1;          // holds a frame count up to MAX_FRAMES
  localparam int DIV_CNT_W  = $clog2(CNT_W);

  localparam int MODE_W     = 3;
  localparam int DELTA_W    = 24;
  localparam int SLOT_W     = 8;
  localparam int DELAY_W    = 32;
  localparam int EVENT_W    = 2;
  localparam int LOOP_W     = 32;
  localparam int TOTAL_W    = 9;
  localparam int SPEED_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int FRAC_W     = 8;                    // Q4.8 speed
  localparam int PROD_W     = DELTA_W + SPEED_W;
  localparam int INC_W      = PROD_W - FRAC_W;
  localparam int ACC_W      = 33;

  localparam logic [SPEED_W-1:0] UNIT_SPEED       = SPEED_W'(1 << FRAC_W);
  localparam logic [DELAY_W-1:0] DEFAULT_DELAY_US = DELAY_W'(100000);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 3'd0,
    MODE_STEP_FWD  = 3'd1,
    MODE_STEP_BACK = 3'd2,
    MODE_PAUSE     = 3'd3,
    MODE_RESUME    = 3'd4,
    MODE_LOAD      = 3'd5,
    MODE_RESTART   = 3'd6
  } mode_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 2'd0,
    EV_ADVANCE = 2'd1,
    EV_LOOP    = 2'd2
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KIND  = 2'd0,
    CFG_TOTAL = 2'd1,
    CFG_SPEED = 2'd2
  } cfg_idx_t;

endpackage

// ===== hw/rtl/afs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read and a write to the same address in one cycle return old data.
module afs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/animation_frame_sequencer.sv =====
// Animation frame sequencer top level.
// Depends on afs_pkg and afs_ram (per-frame delay memory).
//
// Takes one item per cycle while cmd_stall is low and returns one result per
// item (the accept edge loads the item stage and starts the delay memory
// read; the result register loads when that item leaves the item stage).
// The registered read of the frame delay memory sets that stage: the read
// address for the next item is the frame the item in flight leaves behind.
// A step forward from a frame so far beyond a shrunk frame count that one
// subtraction does not wrap it needs a remainder, taken one bit per cycle:
// that item holds the stage until the remainder is done. Delay entries come
// up unwritten after reset; there is no clearing pass. Configuration writes
// are always taken and must only be issued while no item is in flight.
module animation_frame_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  logic [afs_pkg::MODE_W-1:0]     mode,
  input  logic [afs_pkg::DELTA_W-1:0]    delta_us,
  input  logic [afs_pkg::SLOT_W-1:0]     frame_slot,
  input  logic [afs_pkg::DELAY_W-1:0]    delay_us,
  // result channel
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [afs_pkg::EVENT_W-1:0]    event_res,
  output logic [afs_pkg::SLOT_W-1:0]     frame_index,
  output logic [afs_pkg::LOOP_W-1:0]     loop_count,
  output logic                           is_paused,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FRAME_W   = afs_pkg::FRAME_W;
  localparam int CNT_W     = afs_pkg::CNT_W;
  localparam int DIV_CNT_W = afs_pkg::DIV_CNT_W;
  localparam int ACC_W     = afs_pkg::ACC_W;

  logic                          cmd_accept;
  logic                          cfg_accept;

  logic                          frame_kind;
  logic [afs_pkg::TOTAL_W-1:0]   frame_total;
  logic [afs_pkg::SPEED_W-1:0]   play_speed;
  logic [afs_pkg::SPEED_W-1:0]   speed_eff;
  logic [afs_pkg::PROD_W-1:0]    inc_prod;

  logic                          s1_valid;
  afs_pkg::mode_t                s1_mode;
  logic [afs_pkg::INC_W-1:0]     s1_inc;
  logic                          s1_delta_nz;
  logic                          s1_fire;
  logic                          out_free;

  logic [FRAME_W-1:0]            cf;
  logic [FRAME_W-1:0]            cf_next;
  logic [ACC_W-1:0]              acc;
  logic [ACC_W-1:0]              acc_next;
  logic                          paused;
  logic                          paused_next;
  logic [afs_pkg::LOOP_W-1:0]    loops;
  logic [afs_pkg::LOOP_W-1:0]    loops_next;
  afs_pkg::event_t               ev_next;

  logic                          ram_we;
  logic [FRAME_W-1:0]            wr_addr;
  logic [FRAME_W-1:0]            rd_addr;
  logic [afs_pkg::DELAY_W-1:0]   rd_data;
  logic [afs_pkg::DELAY_W-1:0]   delay_eff;

  logic [CNT_W-1:0]              total_eff;
  logic [CNT_W-1:0]              cf_inc;
  logic [CNT_W-1:0]              cf_wrap;
  logic [ACC_W:0]                acc_sum;
  logic [ACC_W-1:0]              acc_sat;
  logic                          tick_live;
  logic                          tick_adv;
  logic                          need_div;

  logic                          div_busy;
  logic                          div_done;
  logic [DIV_CNT_W-1:0]          div_cnt;
  logic [CNT_W-1:0]              div_num;
  logic [CNT_W-1:0]              div_rem;
  logic [CNT_W:0]                div_trial;

  // ---------------------------------------------------------------- handshakes
  assign out_free   = !res_valid || !res_stall;
  assign s1_fire    = s1_valid && out_free && (!need_div || div_done);
  assign cmd_stall  = s1_valid && !s1_fire;
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind  <= 1'b0;
      frame_total <= '0;
      play_speed  <= afs_pkg::UNIT_SPEED;
    end else if (cmd_accept && afs_pkg::mode_t'(mode) == afs_pkg::MODE_RESTART) begin
      // later items must see unit speed already at their multiply
      play_speed <= afs_pkg::UNIT_SPEED;
    end else if (cfg_accept) begin
      unique case (afs_pkg::cfg_idx_t'(cfg_index))
        afs_pkg::CFG_KIND:  frame_kind  <= cfg_data[0];
        afs_pkg::CFG_TOTAL: frame_total <= afs_pkg::TOTAL_W'(cfg_data);
        afs_pkg::CFG_SPEED: play_speed  <= afs_pkg::SPEED_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign total_eff = (32'(frame_total) > 32'(afs_pkg::MAX_FRAMES)) ?
                     CNT_W'(afs_pkg::MAX_FRAMES) : CNT_W'(frame_total);

  // ---------------------------------------------------------------- accept stage
  assign speed_eff = (play_speed == '0) ? afs_pkg::UNIT_SPEED : play_speed;
  assign inc_prod  = afs_pkg::PROD_W'(delta_us) * afs_pkg::PROD_W'(speed_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      s1_mode     <= afs_pkg::mode_t'(mode);
      s1_inc      <= inc_prod[afs_pkg::PROD_W-1:afs_pkg::FRAC_W];
      s1_delta_nz <= (delta_us != '0);
    end
  end

  // Loads write at acceptance. The item ahead reads at the same edge and the
  // memory is read-first, so it still sees the old entry.
  assign ram_we  = cmd_accept && afs_pkg::mode_t'(mode) == afs_pkg::MODE_LOAD &&
                   (32'(frame_slot) < 32'(afs_pkg::MAX_FRAMES));
  assign wr_addr = FRAME_W'(frame_slot);
  assign rd_addr = s1_fire ? cf_next : cf;

  afs_ram #(
    .WIDTH (afs_pkg::DELAY_W),
    .DEPTH (afs_pkg::MAX_FRAMES)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (delay_us),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------- execute stage
  assign cf_inc    = CNT_W'(cf) + CNT_W'(1);
  assign cf_wrap   = cf_inc - total_eff;
  assign need_div  = s1_valid && s1_mode == afs_pkg::MODE_STEP_FWD && total_eff != '0 &&
                     cf_inc >= total_eff && cf_wrap >= total_eff;

  assign tick_live = (total_eff != '0) && !frame_kind && !paused && s1_delta_nz;
  assign acc_sum   = {1'b0, acc} + (ACC_W + 1)'(s1_inc);
  assign acc_sat   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
  assign delay_eff = (rd_data == '0) ? afs_pkg::DEFAULT_DELAY_US : rd_data;
  assign tick_adv  = acc_sat >= ACC_W'(delay_eff);

  always_comb begin
    cf_next     = cf;
    acc_next    = acc;
    paused_next = paused;
    loops_next  = loops;
    ev_next     = afs_pkg::EV_NONE;
    unique case (s1_mode)
      afs_pkg::MODE_TICK: begin
        if (tick_live) begin
          if (tick_adv) begin
            acc_next = '0;
            if (cf_inc >= total_eff) begin
              cf_next    = '0;
              loops_next = loops + afs_pkg::LOOP_W'(1);
              ev_next    = afs_pkg::EV_LOOP;
            end else begin
              cf_next = FRAME_W'(cf_inc);
              ev_next = afs_pkg::EV_ADVANCE;
            end
          end else begin
            acc_next = acc_sat;
          end
        end
      end
      afs_pkg::MODE_STEP_FWD: begin
        if (total_eff != '0) begin
          paused_next = 1'b1;
          acc_next    = '0;
          if (cf_inc < total_eff) begin
            cf_next = FRAME_W'(cf_inc);
          end else if (need_div) begin
            cf_next = FRAME_W'(div_rem);
          end else begin
            cf_next = FRAME_W'(cf_wrap);
          end
        end
      end
      afs_pkg::MODE_STEP_BACK: begin
        if (total_eff != '0) begin
          paused_next = 1'b1;
          acc_next    = '0;
          cf_next     = (cf == '0) ? FRAME_W'(total_eff - CNT_W'(1)) : cf - FRAME_W'(1);
        end
      end
      afs_pkg::MODE_PAUSE: begin
        paused_next = 1'b1;
      end
      afs_pkg::MODE_RESUME: begin
        if (!frame_kind) begin
          paused_next = 1'b0;
        end
      end
      afs_pkg::MODE_LOAD: ;
      afs_pkg::MODE_RESTART: begin
        cf_next     = '0;
        acc_next    = '0;
        paused_next = frame_kind;
        loops_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cf     <= '0;
      acc    <= '0;
      paused <= 1'b0;
      loops  <= '0;
    end else if (s1_fire) begin
      cf     <= cf_next;
      acc    <= acc_next;
      paused <= paused_next;
      loops  <= loops_next;
    end
  end

  // ---------------------------------------------------------------- remainder unit
  // Restoring remainder of (frame + 1) by the frame count, one bit per cycle.
  assign div_trial = {div_rem, div_num[CNT_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else if (s1_fire) begin
      div_done <= 1'b0;
    end else if (div_busy && div_cnt == DIV_CNT_W'(CNT_W - 1)) begin
      div_busy <= 1'b0;
      div_done <= 1'b1;
    end else if (need_div && !div_busy && !div_done) begin
      div_busy <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_busy) begin
      if (div_trial >= {1'b0, total_eff}) begin
        div_rem <= CNT_W'(div_trial - {1'b0, total_eff});
      end else begin
        div_rem <= div_trial[CNT_W-1:0];
      end
      div_num <= div_num << 1;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end else if (!div_done) begin
      div_num <= cf_inc;
      div_rem <= '0;
      div_cnt <= '0;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      event_res   <= ev_next;
      frame_index <= afs_pkg::SLOT_W'(cf_next);
      loop_count  <= loops_next;
      is_paused   <= paused_next;
    end
  end

endmodule

// ===== hw/rtl/animation_frame_sequencer_checker.sv =====
// Port-level checks for the animation frame sequencer, bound to the top level.
// Depends on afs_pkg and animation_frame_sequencer_defines.svh.
`include "animation_frame_sequencer_defines.svh"

module animation_frame_sequencer_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_stall,
  input logic [afs_pkg::EVENT_W-1:0] event_res,
  input logic [afs_pkg::SLOT_W-1:0]  frame_index,
  input logic [afs_pkg::LOOP_W-1:0]  loop_count,
  input logic                        is_paused
);

  `AFS_ASSERT_IMPL(a_event_code, res_valid, event_res == afs_pkg::EV_NONE || event_res == afs_pkg::EV_ADVANCE || event_res == afs_pkg::EV_LOOP, "event code out of range")

  // a wrap always lands on the first frame
  `AFS_ASSERT_IMPL(a_loop_first_frame, res_valid && event_res == afs_pkg::EV_LOOP, frame_index == '0, "looped result not on first frame")

  // only a running tick advances, and a tick leaves the pause flag alone
  `AFS_ASSERT_IMPL(a_advance_running, res_valid && event_res != afs_pkg::EV_NONE, !is_paused, "frame advanced while paused")

  `AFS_ASSERT_NEXT(a_result_held, res_valid && res_stall, res_valid && $stable(event_res) && $stable(frame_index) && $stable(loop_count) && $stable(is_paused), "stalled result changed")

endmodule

bind animation_frame_sequencer animation_frame_sequencer_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .event_res   (event_res),
  .frame_index (frame_index),
  .loop_count  (loop_count),
  .is_paused   (is_paused)
);

// ===== test/animation_frame_sequencer_test.sv =====
// Self-checking testbench for the animation frame sequencer.
// Depends on afs_pkg and the animation_frame_sequencer top level. It predicts every
// result from a shadow copy of the playback state and checks the results in order.
module animation_frame_sequencer_test;
  import afs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNDEFINED = 3'd7;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    event_t              ev;
    logic [SLOT_W-1:0]   frame;
    logic [LOOP_W-1:0]   loops;
    logic                paused;
  } playback_state_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_stall;
  logic [MODE_W-1:0]     mode;
  logic [DELTA_W-1:0]    delta_us;
  logic [SLOT_W-1:0]     frame_slot;
  logic [DELAY_W-1:0]    delay_us;
  logic                  res_valid;
  logic                  res_stall;
  logic [EVENT_W-1:0]    event_res;
  logic [SLOT_W-1:0]     frame_index;
  logic [LOOP_W-1:0]     loop_count;
  logic                  is_paused;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow copy of registers and playback state
  logic                  shadow_kind;
  logic [TOTAL_W-1:0]    shadow_total;
  logic [SPEED_W-1:0]    shadow_speed;
  logic [FRAME_W-1:0]    shadow_frame;
  logic [ACC_W-1:0]      shadow_acc;
  logic                  shadow_paused;
  logic [LOOP_W-1:0]     shadow_loops;
  logic [DELAY_W-1:0]    shadow_delays [MAX_FRAMES];
  bit                    delay_loaded [MAX_FRAMES];

  playback_state_t       expected_frames [$];
  int                    mismatches = 0;
  bit                    sender_idle;
  bit                    receiver_idle;
  int                    long_hold_cycles = 0;

  animation_frame_sequencer DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int frames_in_use();
    return (shadow_total > MAX_FRAMES) ? MAX_FRAMES : int'(shadow_total);
  endfunction

  function automatic void predict_playback(input logic [MODE_W-1:0] op,
                                           input logic [DELTA_W-1:0] delta,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [DELAY_W-1:0] delay);
    int                 n;
    logic [PROD_W-1:0]  scaled;
    logic [ACC_W:0]     sum;
    logic [DELAY_W-1:0] frame_delay;
    playback_state_t    r;
    n = frames_in_use();
    r.ev = EV_NONE;
    case (op)
      MODE_TICK: begin
        if (n != 0 && !shadow_kind && !shadow_paused && delta != '0) begin
          scaled = delta * ((shadow_speed == '0) ? UNIT_SPEED : shadow_speed);
          sum = shadow_acc + scaled[PROD_W-1:FRAC_W];
          shadow_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
          frame_delay = (shadow_delays[shadow_frame] == '0) ? DEFAULT_DELAY_US
                                                             : shadow_delays[shadow_frame];
          if (shadow_acc >= frame_delay) begin
            shadow_acc = '0;
            // a frame beyond a shrunk total also wraps here
            if (int'(shadow_frame) + 1 >= n) begin
              shadow_frame = '0;
              shadow_loops = shadow_loops + 1'b1;
              r.ev = EV_LOOP;
            end else begin
              shadow_frame = shadow_frame + 1'b1;
              r.ev = EV_ADVANCE;
            end
          end
        end
      end
      MODE_STEP_FWD, MODE_STEP_BACK: begin
        if (n != 0) begin
          shadow_paused = 1'b1;
          shadow_acc = '0;
          if (op == MODE_STEP_FWD)
            shadow_frame = FRAME_W'((int'(shadow_frame) + 1) % n);
          else
            shadow_frame = (shadow_frame == '0) ? FRAME_W'(n - 1) : shadow_frame - 1'b1;
        end
      end
      MODE_PAUSE: shadow_paused = 1'b1;
      MODE_RESUME: begin
        if (!shadow_kind)
          shadow_paused = 1'b0;
      end
      MODE_LOAD: begin
        shadow_delays[slot] = delay;
        delay_loaded[slot] = 1'b1;
      end
      MODE_RESTART: begin
        shadow_frame = '0;
        shadow_acc = '0;
        shadow_speed = UNIT_SPEED;
        shadow_paused = shadow_kind;
        shadow_loops = '0;
      end
      default: ;
    endcase
    r.frame = shadow_frame;
    r.loops = shadow_loops;
    r.paused = shadow_paused;
    expected_frames.push_back(r);
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] op,
                           input logic [DELTA_W-1:0] delta = '0,
                           input logic [SLOT_W-1:0] slot = '0,
                           input logic [DELAY_W-1:0] delay = '0);
    @(negedge clk);
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      cmd_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    cmd_valid = 1'b1;
    mode = op;
    delta_us = delta;
    frame_slot = slot;
    delay_us = delay;
    do @(posedge clk); while (cmd_stall);
    predict_playback(op, delta, slot, delay);
  endtask

  // drop valid and let every outstanding item come back
  task automatic wait_idle();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KIND:  shadow_kind = cfg_data[0];
      CFG_TOTAL: shadow_total = cfg_data[TOTAL_W-1:0];
      CFG_SPEED: shadow_speed = cfg_data[SPEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [DELTA_W-1:0] random_delta();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DELTA_W'($urandom);
      default: return DELTA_W'($urandom_range(1, 400));
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] random_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return DELAY_W'($urandom_range(1, 600));
    endcase
  endfunction

  task automatic random_item();
    int                 pick;
    int                 n;
    logic [MODE_W-1:0]  op;
    logic [SLOT_W-1:0]  slot;
    n = frames_in_use();
    pick = $urandom_range(0, 99);
    slot = SLOT_W'($urandom);
    if (pick < 55)      op = MODE_TICK;
    else if (pick < 61) op = MODE_STEP_FWD;
    else if (pick < 67) op = MODE_STEP_BACK;
    else if (pick < 72) op = MODE_PAUSE;
    else if (pick < 86) op = MODE_RESUME;
    else if (pick < 96) op = MODE_LOAD;
    else if (pick < 99) op = MODE_RESTART;
    else                op = MODE_UNDEFINED;
    if (op == MODE_LOAD && n != 0 && $urandom_range(0, 1) == 1)
      slot = SLOT_W'($urandom_range(0, n - 1));
    // a live tick must find its frame's delay written: load it instead
    if (op == MODE_TICK && n != 0 && !shadow_kind && !shadow_paused &&
        !delay_loaded[shadow_frame]) begin
      op = MODE_LOAD;
      slot = shadow_frame;
    end
    send_item(op, random_delta(), slot, random_delay());
  endtask

  // no frames: only pause, resume and restart change anything
  task automatic test_inert_playback();
    send_item(MODE_TICK, '1);
    send_item(MODE_STEP_FWD);
    send_item(MODE_PAUSE);
    send_item(MODE_RESUME);
    send_item(MODE_UNDEFINED, '1, '1, '1);
    send_item(MODE_RESTART);
  endtask

  task automatic test_frame_advance();
    write_reg(CFG_KIND, 0);
    write_reg(CFG_TOTAL, 3);
    write_reg(CFG_SPEED, 0);             // zero plays at unit speed
    send_item(MODE_LOAD, '0, 0, '0);     // default delay
    send_item(MODE_LOAD, '0, 1, 1);
    send_item(MODE_LOAD, '0, 2, 2);
    send_item(MODE_TICK, '0);
    send_item(MODE_TICK, 99999);
    send_item(MODE_TICK, 1);
    send_item(MODE_TICK, '1);
    send_item(MODE_TICK, '1);
    send_item(MODE_STEP_FWD);
    send_item(MODE_TICK, 5);
    send_item(MODE_RESUME);
  endtask

  task automatic test_shrunk_total();
    write_reg(CFG_TOTAL, 300);           // above the table size
    send_item(MODE_RESTART);
    send_item(MODE_STEP_BACK);
    send_item(MODE_LOAD, '0, 255, '1);
    write_reg(CFG_TOTAL, 4);
    send_item(MODE_STEP_FWD);            // from beyond the total
    write_reg(CFG_TOTAL, MAX_FRAMES);
    send_item(MODE_STEP_BACK);
    write_reg(CFG_TOTAL, 4);
    send_item(MODE_STEP_BACK);           // no wrap above the total
    send_item(MODE_LOAD, '0, 254, 1);
    send_item(MODE_RESUME);
    send_item(MODE_TICK, 1);
  endtask

  task automatic test_subpage_mode();
    write_reg(CFG_KIND, 1);
    send_item(MODE_TICK, 1000);
    send_item(MODE_RESUME);
    send_item(MODE_RESTART);
    write_reg(CFG_KIND, 0);
    send_item(MODE_RESTART);
  endtask

  // hold results for a long stretch while items keep coming
  task automatic test_output_backpressure();
    int f;
    write_reg(CFG_KIND, 0);
    write_reg(CFG_TOTAL, 4);
    write_reg(CFG_SPEED, 4095);
    for (f = 0; f < 4; f++)
      send_item(MODE_LOAD, '0, SLOT_W'(f), DELAY_W'($urandom_range(1, 50)));
    send_item(MODE_RESUME);
    sender_idle = 1'b0;
    long_hold_cycles = 150;
    repeat (40) random_item();
    sender_idle = 1'b1;
  endtask

  task automatic test_random_playback(input int phases, input int items_per_phase);
    int p;
    int f;
    int n_frames;
    for (p = 0; p < phases; p++) begin
      if (p >= phases - 2) begin
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
      end
      write_reg(CFG_KIND, $urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0:       n_frames = 0;
        1:       n_frames = MAX_FRAMES;
        2:       n_frames = $urandom_range(0, 511);
        default: n_frames = $urandom_range(1, 8);
      endcase
      write_reg(CFG_TOTAL, n_frames);
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_SPEED, 0);
        1:       write_reg(CFG_SPEED, 4095);
        2:       write_reg(CFG_SPEED, 256);
        default: write_reg(CFG_SPEED, $urandom_range(1, 4095));
      endcase
      for (f = 0; f < n_frames && f < 8; f++)
        send_item(MODE_LOAD, DELTA_W'($urandom), SLOT_W'(f), random_delay());
      send_item(MODE_RESUME, random_delta(), SLOT_W'($urandom), $urandom);
      repeat (items_per_phase) random_item();
    end
  endtask

  initial begin
    int burst;
    burst = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_cycles > 0) begin
        res_stall = 1'b1;
        long_hold_cycles--;
      end else if (burst > 0) begin
        res_stall = 1'b1;
        burst--;
      end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
        res_stall = 1'b1;
        burst = $urandom_range(1, 12) - 1;
      end else begin
        res_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    playback_state_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_frames.size() == 0) begin
        $error("result with no item outstanding: frame_index %0d", frame_index);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        if (event_res !== want.ev) begin
          $error("event_res expected %0d actual %0d", want.ev, event_res);
          mismatches++;
        end
        if (frame_index !== want.frame) begin
          $error("frame_index expected %0d actual %0d", want.frame, frame_index);
          mismatches++;
        end
        if (loop_count !== want.loops) begin
          $error("loop_count expected %0d actual %0d", want.loops, loop_count);
          mismatches++;
        end
        if (is_paused !== want.paused) begin
          $error("is_paused expected %0d actual %0d", want.paused, is_paused);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    mode = MODE_TICK;
    delta_us = '0;
    frame_slot = '0;
    delay_us = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KIND;
    cfg_data = '0;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    shadow_kind = 1'b0;
    shadow_total = '0;
    shadow_speed = UNIT_SPEED;
    shadow_frame = '0;
    shadow_acc = '0;
    shadow_paused = 1'b0;
    shadow_loops = '0;
    foreach (delay_loaded[i]) begin
      delay_loaded[i] = 1'b0;
      shadow_delays[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_inert_playback();
    test_frame_advance();
    test_shrunk_total();
    test_subpage_mode();
    test_output_backpressure();
    test_random_playback(9, 55);

    wait_idle();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
